[src/rdmm_pkg.sv]
`default_nettype none

package rdmm_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W  = CNT_W + 1;

    localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CAPACITY - 1);
    localparam logic [SUM_W-1:0]  CAP_SUM   = SUM_W'(CAPACITY);

    typedef enum logic [2:0] {
        ACT_ADD_FRONT  = 3'd0,
        ACT_ADD_BACK   = 3'd1,
        ACT_DROP_FRONT = 3'd2,
        ACT_DROP_BACK  = 3'd3,
        ACT_REVERSE    = 3'd4,
        ACT_QUERY      = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_POP_EMPTY = 2'd1,
        STS_PUSH_FULL = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SCAN
    } rdmm_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic apply;
        logic scan;
        logic load_out;
    } rdmm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_free;
    } rdmm_stat_t;

endpackage

`default_nettype wire

[src/reversible_deque_min_max.sv]
// Reversible double-ended queue with min/max report.
// Input channel (in_valid/in_ready): one word per request, action plus
// data_value. Output channel (out_valid/out_ready): one result word per
// request with status, entry_count, is_empty, front, back, max and min.
// A request is taken only while the block is idle. It first applies
// the action to the ring store and deque state, then scans the stored
// entries through the single registered read port of the store, one
// entry per cycle. Once the scan is done the result is loaded; the next
// request is taken in the cycle after the result is loaded, so no new
// request is taken while one is in progress.
// The result sits in an output register; if the receiver stalls, the
// block holds the finished scan and loads the register once it frees.
// Reset clears head slot, count, reversal and the handshake state; the
// store contents are not cleared, and no clearing pass is needed.
`default_nettype none

module reversible_deque_min_max
    import rdmm_pkg::*;
(
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  wire        [2:0]  action,
    input  wire signed [31:0] data_value,
    output logic              out_valid,
    input  wire               out_ready,
    output logic       [1:0]  status,
    output logic       [4:0]  entry_count,
    output logic              is_empty,
    output logic signed [31:0] front_value,
    output logic signed [31:0] back_value,
    output logic signed [31:0] max_value,
    output logic signed [31:0] min_value
);

    rdmm_cmd_t  cmd;
    rdmm_stat_t stat;

    rdmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rdmm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .front_value (front_value),
        .back_value  (back_value),
        .max_value   (max_value),
        .min_value   (min_value)
    );

endmodule

`default_nettype wire

[src/rdmm_ctrl.sv]
`default_nettype none

module rdmm_ctrl
    import rdmm_pkg::*;
(
    input  wire             clk,
    input  wire             rst_n,
    input  wire             in_valid,
    output logic            in_ready,
    input  wire rdmm_stat_t stat,
    output rdmm_cmd_t       cmd
);

    rdmm_state_t state_reg;
    rdmm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (stat.scan_done && stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.apply    = 1'b0;
        cmd.scan     = 1'b0;
        cmd.load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            ST_APPLY:
            begin
                cmd.apply = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan     = 1'b1;
                cmd.load_out = stat.scan_done && stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/rdmm_datapath.sv]
`default_nettype none

module rdmm_datapath
    import rdmm_pkg::*;
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire rdmm_cmd_t           cmd,
    output rdmm_stat_t               stat,
    input  wire        [2:0]         action,
    input  wire signed [31:0]        data_value,
    output logic                     out_valid,
    input  wire                      out_ready,
    output logic       [1:0]         status,
    output logic       [4:0]         entry_count,
    output logic                     is_empty,
    output logic signed [31:0]       front_value,
    output logic signed [31:0]       back_value,
    output logic signed [31:0]       max_value,
    output logic signed [31:0]       min_value
);

    logic [VALUE_BITS-1:0] mem [CAPACITY];

    // latched request word
    action_t                      act_reg;
    logic signed [VALUE_BITS-1:0] data_reg;

    // deque state
    logic [SLOT_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rev_reg, rev_next;
    status_t           sts_reg, sts_next;

    // write port
    logic                  we;
    logic [SLOT_W-1:0]     wr_addr;

    // scan
    logic [CNT_W-1:0]             rd_idx_reg, rd_idx_next;
    logic [SLOT_W-1:0]            rd_ptr_reg, rd_ptr_next;
    logic                         pend_reg, pend_next;
    logic [CNT_W-1:0]             pend_off_reg;
    logic                         re;
    logic signed [VALUE_BITS-1:0] rd_data_reg;
    logic signed [VALUE_BITS-1:0] head_reg, tail_reg, mx_reg, mn_reg;

    logic out_valid_reg;

    logic [SLOT_W-1:0] first_prev, first_succ, tail_slot, rd_ptr_succ;
    logic [SUM_W-1:0]  tail_sum;
    logic              is_full, is_void, at_head;

    assign first_prev  = (first_reg == '0) ? LAST_SLOT : first_reg - SLOT_W'(1);
    assign first_succ  = (first_reg == LAST_SLOT) ? '0 : first_reg + SLOT_W'(1);
    assign rd_ptr_succ = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + SLOT_W'(1);
    assign tail_sum    = SUM_W'(first_reg) + SUM_W'(count_reg);
    assign tail_slot   = (tail_sum >= CAP_SUM) ? SLOT_W'(tail_sum - CAP_SUM)
                                               : SLOT_W'(tail_sum);
    assign is_full     = (count_reg == CAP_CNT);
    assign is_void     = (count_reg == '0);

    // state update for the latched request
    always_comb
    begin
        first_next = first_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        sts_next   = sts_reg;
        we         = 1'b0;
        wr_addr    = tail_slot;
        at_head    = 1'b0;
        if (cmd.apply)
        begin
            sts_next = STS_OK;
            case (act_reg) inside
                ACT_ADD_FRONT, ACT_ADD_BACK:
                begin
                    at_head = (act_reg == ACT_ADD_FRONT) ? !rev_reg : rev_reg;
                    if (is_full)
                    begin
                        sts_next = STS_PUSH_FULL;
                    end
                    else
                    begin
                        we         = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (at_head)
                        begin
                            first_next = first_prev;
                            wr_addr    = first_prev;
                        end
                    end
                end
                ACT_DROP_FRONT, ACT_DROP_BACK:
                begin
                    at_head = (act_reg == ACT_DROP_FRONT) ? !rev_reg : rev_reg;
                    if (is_void)
                    begin
                        sts_next = STS_POP_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                        if (at_head)
                        begin
                            first_next = first_succ;
                        end
                    end
                end
                ACT_REVERSE:
                begin
                    rev_next = !rev_reg;
                end
                default:
                begin
                    sts_next = STS_OK;
                end
            endcase
        end
    end

    // one read issued per scan cycle until all entries are read, data back in the next cycle
    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        rd_ptr_next = rd_ptr_reg;
        pend_next   = 1'b0;
        re          = 1'b0;
        if (cmd.apply)
        begin
            rd_idx_next = '0;
            rd_ptr_next = first_next;
        end
        else if (cmd.scan && (rd_idx_reg != count_reg))
        begin
            re          = 1'b1;
            pend_next   = 1'b1;
            rd_idx_next = rd_idx_reg + CNT_W'(1);
            rd_ptr_next = rd_ptr_succ;
        end
    end

    assign stat.scan_done = (rd_idx_reg == count_reg) && !pend_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= VALUE_BITS'(data_reg);
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            rd_idx_reg    <= '0;
            rd_ptr_reg    <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            first_reg  <= first_next;
            count_reg  <= count_next;
            rev_reg    <= rev_next;
            rd_idx_reg <= rd_idx_next;
            rd_ptr_reg <= rd_ptr_next;
            pend_reg   <= pend_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sts_reg <= sts_next;
        if (cmd.load_in)
        begin
            act_reg  <= action_t'(action);
            data_reg <= VALUE_BITS'(data_value);
        end
        if (re)
        begin
            pend_off_reg <= rd_idx_reg;
        end
        if (pend_reg)
        begin
            if (pend_off_reg == '0)
            begin
                head_reg <= rd_data_reg;
                mx_reg   <= rd_data_reg;
                mn_reg   <= rd_data_reg;
            end
            else
            begin
                if (rd_data_reg > mx_reg)
                begin
                    mx_reg <= rd_data_reg;
                end
                if (rd_data_reg < mn_reg)
                begin
                    mn_reg <= rd_data_reg;
                end
            end
            if (pend_off_reg == count_reg - CNT_W'(1))
            begin
                tail_reg <= rd_data_reg;
            end
        end
        if (cmd.load_out)
        begin
            status      <= sts_reg;
            entry_count <= 5'(count_reg);
            is_empty    <= is_void;
            if (is_void)
            begin
                front_value <= '0;
                back_value  <= '0;
                max_value   <= '0;
                min_value   <= '0;
            end
            else
            begin
                front_value <= rev_reg ? 32'(tail_reg) : 32'(head_reg);
                back_value  <= rev_reg ? 32'(head_reg) : 32'(tail_reg);
                max_value   <= 32'(mx_reg);
                min_value   <= 32'(mn_reg);
            end
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_first_bound: assert property (@(posedge clk) disable iff (!rst_n)
        first_reg <= LAST_SLOT)
        else $error("head slot out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before taken");

    a_pend_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (pend_off_reg < count_reg))
        else $error("scan read beyond stored entries");

    a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |=> (count_reg == $past(count_reg) && first_reg == $past(first_reg)))
        else $error("deque state moved during scan");
`endif

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rdmm_pkg::*;

    // action codes the block treats as a plain query
    localparam logic [2:0] ACT_SPARE_LO = 3'd6;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES = CAPACITY + 8;

    typedef struct packed {
        logic [2:0]         act;
        logic signed [31:0] val;
    } request_t;

    typedef struct packed {
        logic [1:0]         sts;
        logic [4:0]         count;
        logic               empty;
        logic signed [31:0] front;
        logic signed [31:0] back;
        logic signed [31:0] maxv;
        logic signed [31:0] minv;
    } deque_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [2:0]         action = ACT_QUERY;
    logic signed [31:0] data_value = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [1:0]         status;
    logic [4:0]         entry_count;
    logic               is_empty;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic signed [31:0] max_value;
    logic signed [31:0] min_value;

    request_t      pending_requests[$];
    deque_result_t expected_results[$];

    // shadow deque
    logic signed [31:0] dq_ring[CAPACITY];
    int                 dq_head = 0;
    int                 dq_count = 0;
    logic               dq_rev = 1'b0;

    int       idle_in_pct = 0;
    int       stall_out_pct = 0;
    int       hold_req = 0;
    int       hold_ack = 0;
    int       hold_left = 0;
    logic     in_taken = 1'b0;
    request_t next_req;

    int mismatches = 0;
    int n_results = 0;
    int n_full_drops = 0;
    int n_empty_pops = 0;
    int n_reversals = 0;
    int peak_count = 0;

    reversible_deque_min_max u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .data_value  (data_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .entry_count (entry_count),
        .is_empty    (is_empty),
        .front_value (front_value),
        .back_value  (back_value),
        .max_value   (max_value),
        .min_value   (min_value)
    );

    function automatic deque_result_t deque_apply(input logic [2:0] act,
                                                  input logic signed [31:0] val);
        deque_result_t      r;
        logic               at_head;
        logic signed [31:0] h;
        logic signed [31:0] t;
        logic signed [31:0] e;
        r = '0;
        r.sts = STS_OK;
        case (act)
            ACT_ADD_FRONT, ACT_ADD_BACK:
            begin
                if (dq_count >= CAPACITY)
                begin
                    r.sts = STS_PUSH_FULL;
                end
                else
                begin
                    at_head = (act == ACT_ADD_FRONT) ^ dq_rev;
                    if (at_head)
                    begin
                        dq_head = (dq_head + CAPACITY - 1) % CAPACITY;
                        dq_ring[dq_head] = val;
                    end
                    else
                    begin
                        dq_ring[(dq_head + dq_count) % CAPACITY] = val;
                    end
                    dq_count++;
                end
            end
            ACT_DROP_FRONT, ACT_DROP_BACK:
            begin
                if (dq_count == 0)
                begin
                    r.sts = STS_POP_EMPTY;
                end
                else
                begin
                    at_head = (act == ACT_DROP_FRONT) ^ dq_rev;
                    if (at_head)
                        dq_head = (dq_head + 1) % CAPACITY;
                    dq_count--;
                end
            end
            ACT_REVERSE:
            begin
                dq_rev = !dq_rev;
            end
            default:
            begin
            end
        endcase
        r.count = 5'(dq_count);
        r.empty = (dq_count == 0);
        if (dq_count != 0)
        begin
            h = dq_ring[dq_head];
            t = dq_ring[(dq_head + dq_count - 1) % CAPACITY];
            r.front = dq_rev ? t : h;
            r.back = dq_rev ? h : t;
            r.maxv = h;
            r.minv = h;
            for (int i = 1; i < dq_count; i++)
            begin
                e = dq_ring[(dq_head + i) % CAPACITY];
                if (e > r.maxv)
                    r.maxv = e;
                if (e < r.minv)
                    r.minv = e;
            end
        end
        return r;
    endfunction

    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return -32'sd1;
            4, 5: return 32'($signed($urandom_range(7)) - 4);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_req(input logic [2:0] act, input logic signed [31:0] val);
        request_t req;
        req.act = act;
        req.val = val;
        pending_requests.insert(pending_requests.size(), req);
    endtask

    // bursts lean toward filling, draining or neither so the count wanders
    // over the whole range, full and empty included
    task automatic queue_random(input int n);
        int left;
        int burst;
        int push_pct;
        int pop_pct;
        int r;
        logic [2:0] act;
        left = n;
        while (left > 0)
        begin
            burst = $urandom_range(24, 6);
            case ($urandom_range(2))
                0: begin push_pct = 60; pop_pct = 22; end
                1: begin push_pct = 20; pop_pct = 62; end
                default: begin push_pct = 38; pop_pct = 38; end
            endcase
            for (int i = 0; i < burst && left > 0; i++)
            begin
                r = $urandom_range(99);
                if (r < push_pct)
                    act = $urandom_range(1) ? ACT_ADD_BACK : ACT_ADD_FRONT;
                else if (r < push_pct + pop_pct)
                    act = $urandom_range(1) ? ACT_DROP_BACK : ACT_DROP_FRONT;
                else if (r < push_pct + pop_pct + 9)
                    act = ACT_REVERSE;
                else if (r < push_pct + pop_pct + 14)
                    act = ACT_QUERY;
                else
                    act = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
                queue_req(act, pick_value());
                left--;
            end
        end
    endtask

    task automatic drain_all();
        wait (pending_requests.size() == 0 && !in_valid && expected_results.size() == 0);
    endtask

    initial
    begin
        forever #10 clk = ~clk;
    end

    // sender
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_taken)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= idle_in_pct)
                begin
                    next_req = pending_requests[0];
                    pending_requests.delete(0);
                    in_valid <= 1'b1;
                    action <= next_req.act;
                    data_value <= next_req.val;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_req != hold_ack)
            begin
                hold_ack <= hold_req;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= stall_out_pct);
            end
        end
    end

    // predict on each accepted word, check each delivered word
    always @(posedge clk)
    begin
        deque_result_t exp_r;
        deque_result_t got_r;
        if (rst_n)
        begin
            in_taken <= in_valid && in_ready;
            if (in_valid && in_ready)
            begin
                exp_r = deque_apply(action, data_value);
                expected_results.insert(expected_results.size(), exp_r);
                if (exp_r.sts == STS_PUSH_FULL)
                    n_full_drops++;
                if (exp_r.sts == STS_POP_EMPTY)
                    n_empty_pops++;
                if (action == ACT_REVERSE)
                    n_reversals++;
                if (exp_r.count > peak_count)
                    peak_count = exp_r.count;
            end
            if (out_valid && out_ready)
            begin
                got_r.sts = status;
                got_r.count = entry_count;
                got_r.empty = is_empty;
                got_r.front = front_value;
                got_r.back = back_value;
                got_r.maxv = max_value;
                got_r.minv = min_value;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result word at %0t", $realtime);
                end
                else
                begin
                    exp_r = expected_results[0];
                    expected_results.delete(0);
                    n_results++;
                    if (got_r !== exp_r)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch on result %0d at %0t", n_results, $realtime);
                            $display("  exp sts=%0d n=%0d e=%0d f=%0d b=%0d max=%0d min=%0d",
                                     exp_r.sts, exp_r.count, exp_r.empty, exp_r.front,
                                     exp_r.back, exp_r.maxv, exp_r.minv);
                            $display("  got sts=%0d n=%0d e=%0d f=%0d b=%0d max=%0d min=%0d",
                                     got_r.sts, got_r.count, got_r.empty, got_r.front,
                                     got_r.back, got_r.maxv, got_r.minv);
                        end
                    end
                end
            end
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty cases, extremes, reversal, fill to full
        queue_req(ACT_QUERY, 32'sh1234_5678);
        queue_req(ACT_DROP_FRONT, -32'sd1);
        queue_req(ACT_DROP_BACK, 32'sh8000_0000);
        queue_req(ACT_SPARE_LO, 32'sh7FFF_FFFF);
        queue_req(ACT_ADD_FRONT, 32'sh7FFF_FFFF);
        queue_req(ACT_ADD_BACK, 32'sh8000_0000);
        queue_req(ACT_REVERSE, '0);
        queue_req(ACT_ADD_FRONT, -32'sd1);
        queue_req(ACT_ADD_BACK, '0);
        for (int i = 0; i < CAPACITY - 4; i++)
            queue_req((i % 2) ? ACT_ADD_BACK : ACT_ADD_FRONT, $urandom);
        queue_req(ACT_ADD_BACK, 32'sh5555_5555);
        queue_req(ACT_ADD_FRONT, 32'shAAAA_AAAA);
        queue_req(ACT_DROP_FRONT, '0);
        queue_req(ACT_DROP_BACK, '0);
        queue_req(ACT_SPARE_HI, -32'sd1);
        queue_req(ACT_REVERSE, '0);
        drain_all();

        // no idling; a long receiver hold-off backs up the sender
        queue_random(100);
        hold_req = hold_req + 1;
        queue_random(105);
        drain_all();

        // sender idles, with a full pause halfway
        idle_in_pct = 62;
        queue_random(100);
        drain_all();
        queue_random(105);
        drain_all();

        // receiver stalls
        idle_in_pct = 0;
        stall_out_pct = 62;
        queue_random(205);
        drain_all();

        // both sides
        idle_in_pct = 28;
        stall_out_pct = 28;
        queue_random(205);
        drain_all();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0d results never arrived", expected_results.size());
            mismatches += expected_results.size();
        end

        $display("checked %0d results: %0d reversals, %0d dropped pushes, %0d empty pops",
                 n_results, n_reversals, n_full_drops, n_empty_pops);
        $display("peak occupancy %0d of %0d, %0d mismatches", peak_count, CAPACITY, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("timeout with %0d results outstanding", expected_results.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
